FILE: design/apt_pkg.sv
`default_nettype none

package apt_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned OpndW     = CoordW + 1;
  localparam int unsigned ProdW     = CoefW + OpndW;
  localparam int unsigned FracShift = 12;
  localparam int unsigned AddW      = CoordW + FracShift;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned RndW      = AccW - FracShift;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = NumAxes * CoefW;

  localparam logic [CoefW-1:0] COEF_ONE = CoefW'(1 << FracShift);

  typedef enum logic [1:0] {
    CMD_FWD_POINT = 2'd0,
    CMD_FWD_DIR   = 2'd1,
    CMD_INV_POINT = 2'd2,
    CMD_INV_DIR   = 2'd3
  } apt_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AXIS_X   = 3'd0,
    REG_AXIS_Y   = 3'd1,
    REG_AXIS_Z   = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } apt_reg_e;

  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [CoordW-1:0] coord_t;

  // Load strobes for the lane pipeline registers.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } apt_ctrl_t;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } apt_lane_res_t;

endpackage

`default_nettype wire

FILE: design/apt_if.sv
`default_nettype none

interface apt_in_if;
  import apt_pkg::*;

  logic     valid;
  logic     ready;
  apt_cmd_e cmd;
  coord_t   in_x;
  coord_t   in_y;
  coord_t   in_z;

  modport source (output valid, cmd, in_x, in_y, in_z, input ready);
  modport sink   (input valid, cmd, in_x, in_y, in_z, output ready);
endinterface

interface apt_out_if;
  import apt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

FILE: design/apt_lane.sv
`default_nettype none

module apt_lane (
  input  logic                   clk_i,
  input  apt_pkg::apt_ctrl_t     ctrl_i,
  input  apt_pkg::apt_cmd_e      cmd_i,
  input  apt_pkg::coord_t        vec_i      [apt_pkg::NumAxes],
  input  apt_pkg::coord_t        off_i      [apt_pkg::NumAxes],
  input  apt_pkg::coord_t        add_off_i,
  input  apt_pkg::coef_t         coef_fwd_i [apt_pkg::NumAxes],
  input  apt_pkg::coef_t         coef_inv_i [apt_pkg::NumAxes],
  output apt_pkg::apt_lane_res_t res_o
);
  import apt_pkg::*;

  localparam logic signed [AccW-1:0] RndBias = AccW'(1 << (FracShift - 1));

  logic                    inverse;
  logic                    with_off;
  logic signed [OpndW-1:0] opnd_d [NumAxes];
  logic signed [OpndW-1:0] opnd_q [NumAxes];
  coef_t                   coef_d [NumAxes];
  coef_t                   coef_q [NumAxes];
  logic signed [AddW-1:0]  add1_d;
  logic signed [AddW-1:0]  add1_q;
  logic signed [ProdW-1:0] prod_d [NumAxes];
  logic signed [ProdW-1:0] prod_q [NumAxes];
  logic signed [AddW-1:0]  add2_q;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  rnd;
  logic        [RndW-1:0]  quo;
  logic                    ovf;

  // Stage 1: coefficients, operand (inverse point: difference), forward offset.
  always_comb begin
    inverse  = (cmd_i == CMD_INV_POINT) || (cmd_i == CMD_INV_DIR);
    with_off = (cmd_i == CMD_FWD_POINT) || (cmd_i == CMD_INV_POINT);
    for (int j = 0; j < NumAxes; j++) begin
      if (inverse && with_off) begin
        opnd_d[j] = OpndW'(vec_i[j]) - OpndW'(off_i[j]);
      end else begin
        opnd_d[j] = OpndW'(vec_i[j]);
      end
      coef_d[j] = inverse ? coef_inv_i[j] : coef_fwd_i[j];
    end
    if (!inverse && with_off) begin
      add1_d = {add_off_i, {FracShift{1'b0}}};
    end else begin
      add1_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      opnd_q <= opnd_d;
      coef_q <= coef_d;
      add1_q <= add1_d;
    end
  end

  // Stage 2: one multiplier per term.
  always_comb begin
    for (int j = 0; j < NumAxes; j++) begin
      prod_d[j] = ProdW'(coef_q[j]) * ProdW'(opnd_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      prod_q <= prod_d;
      add2_q <= add1_q;
    end
  end

  // Stage 3: exact sum in Q.28.
  assign acc_d = AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2]) + AccW'(add2_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      acc_q <= acc_d;
    end
  end

  // Round half up to Q16.16, then clip to 32 bits.
  always_comb begin
    rnd = acc_q + RndBias;
    quo = rnd[AccW-1:FracShift];
    ovf = (quo[RndW-1:CoordW-1] != {(RndW-CoordW+1){1'b0}}) &&
          (quo[RndW-1:CoordW-1] != {(RndW-CoordW+1){1'b1}});
    res_o.sat = ovf;
    if (ovf) begin
      res_o.value = quo[RndW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      res_o.value = quo[CoordW-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/apt_merge.sv
`default_nettype none

module apt_merge (
  input  logic                   clk_i,
  input  logic                   ld_i,
  input  apt_pkg::apt_lane_res_t res_i [apt_pkg::NumAxes],
  output apt_pkg::coord_t        out_x_o,
  output apt_pkg::coord_t        out_y_o,
  output apt_pkg::coord_t        out_z_o,
  output logic                   sat_o
);
  import apt_pkg::*;

  coord_t x_q, y_q, z_q;
  logic   sat_d, sat_q;

  // Flag the item if any lane clipped.
  assign sat_d = res_i[0].sat | res_i[1].sat | res_i[2].sat;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      x_q   <= res_i[0].value;
      y_q   <= res_i[1].value;
      z_q   <= res_i[2].value;
      sat_q <= sat_d;
    end
  end

  assign out_x_o = x_q;
  assign out_y_o = y_q;
  assign out_z_o = z_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

FILE: design/affine_point_transform_top.sv
// Path: operands and coefficients are registered, then products, then the sum, then the rounded
// result in the output register.
// Throughput: one item per cycle; each stage holds while the stage after it is full and stalled.
// Three lanes, one per result component, each with three 16x33 multipliers set the pace.
// Reset: asynchronous, active low; clears all valid bits and loads the identity axes and a
// zero translation into the configuration registers.
`default_nettype none

module affine_point_transform_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apt_pkg::CfgDataW-1:0] cfg_data_i,
  apt_in_if.sink                       in_if,
  apt_out_if.source                    out_if
);
  import apt_pkg::*;

  // Configuration registers: three axes of packed Q4.12, translation in Q16.16.
  logic [CfgDataW-1:0] axis_q [NumAxes];
  coord_t              off_q  [NumAxes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0] <= {{(2*CoefW){1'b0}}, COEF_ONE};
      axis_q[1] <= {{CoefW{1'b0}}, COEF_ONE, {CoefW{1'b0}}};
      axis_q[2] <= {COEF_ONE, {(2*CoefW){1'b0}}};
      off_q[0]  <= '0;
      off_q[1]  <= '0;
      off_q[2]  <= '0;
    end else if (cfg_we_i) begin
      unique case (apt_reg_e'(cfg_idx_i))
        REG_AXIS_X:   axis_q[0] <= cfg_data_i;
        REG_AXIS_Y:   axis_q[1] <= cfg_data_i;
        REG_AXIS_Z:   axis_q[2] <= cfg_data_i;
        REG_OFFSET_X: off_q[0]  <= cfg_data_i[CoordW-1:0];
        REG_OFFSET_Y: off_q[1]  <= cfg_data_i[CoordW-1:0];
        REG_OFFSET_Z: off_q[2]  <= cfg_data_i[CoordW-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Pipeline occupancy. A stage is free when it is empty or its item moves on this cycle,
  // so bubbles collapse and a waiting result blocks a stage only when every stage between them is full.
  logic      v1_q, v2_q, v3_q, out_v_q;
  logic      free_1, free_2, free_3, free_out;
  apt_ctrl_t ctrl;

  assign free_out = !out_v_q || out_if.ready;
  assign free_3   = !v3_q || free_out;
  assign free_2   = !v2_q || free_3;
  assign free_1   = !v1_q || free_2;

  assign ctrl.ld1 = free_1;
  assign ctrl.ld2 = free_2;
  assign ctrl.ld3 = free_3;

  assign in_if.ready = free_1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (free_1) begin
        v1_q <= in_if.valid;
      end
      if (free_2) begin
        v2_q <= v1_q;
      end
      if (free_3) begin
        v3_q <= v2_q;
      end
      if (free_out) begin
        out_v_q <= v3_q;
      end
    end
  end

  // Input vector as an array for the lanes.
  coord_t vec [NumAxes];
  assign vec[0] = in_if.in_x;
  assign vec[1] = in_if.in_y;
  assign vec[2] = in_if.in_z;

  // Lane k computes result component k. Forward: column k of the axes (component k of
  // every axis). Inverse: row k (all components of axis k).
  apt_lane_res_t lane_res [NumAxes];

  for (genvar k = 0; k < NumAxes; k++) begin : g_lane
    coef_t coef_fwd [NumAxes];
    coef_t coef_inv [NumAxes];

    for (genvar i = 0; i < NumAxes; i++) begin : g_coef
      assign coef_fwd[i] = axis_q[i][k*CoefW +: CoefW];
      assign coef_inv[i] = axis_q[k][i*CoefW +: CoefW];
    end

    apt_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cmd_i      (in_if.cmd),
      .vec_i      (vec),
      .off_i      (off_q),
      .add_off_i  (off_q[k]),
      .coef_fwd_i (coef_fwd),
      .coef_inv_i (coef_inv),
      .res_o      (lane_res[k])
    );
  end

  // Merge the lane results into the output register.
  apt_merge u_merge (
    .clk_i   (clk_i),
    .ld_i    (free_out),
    .res_i   (lane_res),
    .out_x_o (out_if.out_x),
    .out_y_o (out_if.out_y),
    .out_z_o (out_if.out_z),
    .sat_o   (out_if.saturated)
  );

  assign out_if.valid = out_v_q;

  // An input transfer always lands in the first stage.
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> v1_q)
    else $error("accepted item not held in first stage");

  // A full stage whose successor cannot take it keeps its item.
  a_stage2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !free_3) |=> v2_q)
    else $error("second stage dropped a stalled item");

  // A finished item reaches an empty output register in the next cycle.
  a_out_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !out_v_q) |=> out_v_q)
    else $error("finished item did not reach the output register");

  // Input ready only drops while the whole pipeline is occupied.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (v1_q && v2_q && v3_q && out_v_q))
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

FILE: tb/tb_affine_point_transform_top.sv
`default_nettype none

module tb_affine_point_transform_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apt_pkg::*;

  // Result of one transform as the output channel carries it.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } point_res_t;

  // One line of stimulus: either a register write or a point to transform.
  // When typed is set, want holds the expected result as written in the table.
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    apt_cmd_e            cmd;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                typed;
    point_res_t          want;
  } stim_row_t;

  // How the axes and the translation are drawn for one random phase.
  typedef enum logic [1:0] {
    STYLE_IDENTITY,
    STYLE_RANDOM,
    STYLE_NEAR_UNIT,
    STYLE_EXTREME
  } cfg_style_e;

  // Register indexes that the block does not decode.
  localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = 3'd7;

  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  localparam coord_t           COORD_EDGES [5] = '{CMAX, CMIN, 32'sd0, -32'sd1, 32'sd1};
  localparam logic [CoefW-1:0] COEF_EDGES  [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned TAIL_CYCLES = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  apt_in_if  in_ch ();
  apt_out_if out_ch ();

  affine_point_transform_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // Shadow copy of the configuration registers, kept in step with every write.
  logic [CfgDataW-1:0] axis_q   [NumAxes];
  coord_t              offset_q [NumAxes];

  // Results still owed by the block, oldest first.
  point_res_t want_points [$];
  int unsigned bad_count;

  // Sender burst bookkeeping and receiver stall pattern.
  int unsigned burst_left;
  int unsigned hold_left;
  logic [15:0] stall_pat;

  stim_row_t dir_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block wedges or drops results.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Predict one result from the shadow registers. All sums are exact at 64 bits,
  // then rounded once (halves toward plus infinity) and clipped to Q16.16.
  function automatic point_res_t transform_point(input stim_row_t row);
    logic signed [63:0]      vec [NumAxes];
    logic signed [63:0]      acc;
    logic signed [63:0]      rnd;
    logic signed [63:0]      off;
    logic signed [CoefW-1:0] cf;
    logic                    inverse;
    coord_t                  lane [NumAxes];
    point_res_t              res;
    inverse = (row.cmd == CMD_INV_POINT) || (row.cmd == CMD_INV_DIR);
    vec[0]  = row.x;
    vec[1]  = row.y;
    vec[2]  = row.z;
    res.sat = 1'b0;
    // Inverse point: subtract the translation at full width, no clipping here.
    if (row.cmd == CMD_INV_POINT) begin
      for (int j = 0; j < NumAxes; j++) begin
        off    = offset_q[j];
        vec[j] = vec[j] - off;
      end
    end
    for (int k = 0; k < NumAxes; k++) begin
      acc = '0;
      for (int m = 0; m < NumAxes; m++) begin
        // Inverse takes dot products with axis k; forward weights axis m by input m.
        cf  = inverse ? axis_q[k][CoefW*m +: CoefW] : axis_q[m][CoefW*k +: CoefW];
        acc = acc + cf * vec[m];
      end
      if (row.cmd == CMD_FWD_POINT) begin
        off = offset_q[k];
        acc = acc + (off <<< FracShift);
      end
      rnd = (acc + (64'sd1 <<< (FracShift - 1))) >>> FracShift;
      if (rnd > CMAX) begin
        lane[k] = CMAX;
        res.sat = 1'b1;
      end else if (rnd < CMIN) begin
        lane[k] = CMIN;
        res.sat = 1'b1;
      end else begin
        lane[k] = rnd[CoordW-1:0];
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row        = '0;
    row.cmd    = CMD_FWD_POINT;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic stim_row_t pt_row(input apt_cmd_e cmd, input coord_t x,
                                       input coord_t y, input coord_t z);
    stim_row_t row;
    row     = '0;
    row.cmd = cmd;
    row.x   = x;
    row.y   = y;
    row.z   = z;
    return row;
  endfunction

  function automatic stim_row_t want_row(input apt_cmd_e cmd, input coord_t x, input coord_t y,
                                         input coord_t z, input coord_t ex, input coord_t ey,
                                         input coord_t ez, input logic es);
    stim_row_t row;
    row          = pt_row(cmd, x, y, z);
    row.typed    = 1'b1;
    row.want.x   = ex;
    row.want.y   = ey;
    row.want.z   = ez;
    row.want.sat = es;
    return row;
  endfunction

  // Mix of full-range values, small magnitudes around zero and the range edges.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_EDGES[$urandom_range(0, 4)];
      1:       return coord_t'($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Write one register at a falling edge, hold the strobe for one cycle, then drop it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_AXIS_X:   axis_q[0]   = data;
      REG_AXIS_Y:   axis_q[1]   = data;
      REG_AXIS_Z:   axis_q[2]   = data;
      REG_OFFSET_X: offset_q[0] = data[CoordW-1:0];
      REG_OFFSET_Y: offset_q[1] = data[CoordW-1:0];
      REG_OFFSET_Z: offset_q[2] = data[CoordW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every owed result has come back; since every
  // point yields one result, an empty queue means the pipeline is empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (want_points.size() != 0) @(negedge clk_i);
  endtask

  // Offer one point. Open a new burst with a random gap when the last one ran
  // out, hold the payload until the transfer, then log the expected result.
  task automatic push_point(input stim_row_t row);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= row.cmd;
    in_ch.in_x  <= row.x;
    in_ch.in_y  <= row.y;
    in_ch.in_z  <= row.z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    want_points.push_back(row.typed ? row.want : transform_point(row));
    burst_left--;
    @(negedge clk_i);
  endtask

  // Receiver: rotate a 16-bit ready pattern, reloaded after a random hold.
  // Patterns range from always ready to mostly stalled.
  always @(negedge clk_i) begin
    if (hold_left == 0) begin
      hold_left = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom);
        default: stall_pat = 16'h1111 << $urandom_range(0, 3);
      endcase
    end
    hold_left--;
    stall_pat    = {stall_pat[0], stall_pat[15:1]};
    out_ch.ready <= stall_pat[0];
  end

  // Check every output transfer against the oldest owed result.
  always @(posedge clk_i) begin : check_out
    point_res_t got;
    point_res_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.x   = out_ch.out_x;
      got.y   = out_ch.out_y;
      got.z   = out_ch.out_z;
      got.sat = out_ch.saturated;
      if (want_points.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b",
                   $realtime, got.x, got.y, got.z, got.sat);
        end
      end else begin
        exp_res = want_points.pop_front();
        if (got !== exp_res) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("%0t: exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                     $realtime, exp_res.x, exp_res.y, exp_res.z, exp_res.sat,
                     got.x, got.y, got.z, got.sat);
          end
        end
      end
    end
  end

  initial begin : main_seq
    stim_row_t           row;
    cfg_style_e          style;
    logic [CfgDataW-1:0] word;
    logic [CoefW-1:0]    cf;
    coord_t              off;

    // Drive every input to a known value before the first edge.
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.cmd    = CMD_FWD_POINT;
    in_ch.in_x   = '0;
    in_ch.in_y   = '0;
    in_ch.in_z   = '0;
    bad_count    = 0;
    burst_left   = 0;

    // Shadow registers start at the reset values: identity axes, no translation.
    axis_q[0]   = CfgDataW'(COEF_ONE);
    axis_q[1]   = CfgDataW'(COEF_ONE) << CoefW;
    axis_q[2]   = CfgDataW'(COEF_ONE) << (2 * CoefW);
    offset_q[0] = '0;
    offset_q[1] = '0;
    offset_q[2] = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. After reset the transform is the identity for every command,
    // so those rows carry the input as the expected result.
    dir_rows.push_back(want_row(CMD_FWD_POINT, 0, 0, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(want_row(CMD_FWD_POINT, CMAX, CMIN, -1, CMAX, CMIN, -1, 1'b0));
    dir_rows.push_back(want_row(CMD_FWD_DIR, CMIN, CMAX, 1, CMIN, CMAX, 1, 1'b0));
    dir_rows.push_back(want_row(CMD_INV_POINT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0));
    dir_rows.push_back(want_row(CMD_INV_DIR, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0));
    dir_rows.push_back(want_row(CMD_INV_POINT, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f,
                                32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 1'b0));
    // Writes to undecoded indexes must leave the identity in place.
    dir_rows.push_back(cfg_row(IDX_SPARE_LO, '1));
    dir_rows.push_back(cfg_row(IDX_SPARE_HI, '1));
    dir_rows.push_back(want_row(CMD_FWD_POINT, 12345, -1, 7, 12345, -1, 7, 1'b0));
    // Zero axes: a forward point yields the translation, the rest yield zero.
    // Upper data bits of an offset write are junk and must be dropped.
    dir_rows.push_back(cfg_row(REG_AXIS_X, '0));
    dir_rows.push_back(cfg_row(REG_AXIS_Y, '0));
    dir_rows.push_back(cfg_row(REG_AXIS_Z, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_X, {16'hffff, CMAX}));
    dir_rows.push_back(cfg_row(REG_OFFSET_Y, {16'h5a5a, CMIN}));
    dir_rows.push_back(cfg_row(REG_OFFSET_Z, {16'h0000, -32'sd5}));
    dir_rows.push_back(want_row(CMD_FWD_POINT, 1, 2, 3, CMAX, CMIN, -5, 1'b0));
    dir_rows.push_back(want_row(CMD_FWD_DIR, CMAX, CMAX, CMAX, 0, 0, 0, 1'b0));
    dir_rows.push_back(want_row(CMD_INV_POINT, CMIN, CMAX, 0, 0, 0, 0, 1'b0));
    // Near-8.0 gain on x alone: full-scale inputs clip and raise the flag.
    dir_rows.push_back(cfg_row(REG_OFFSET_X, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_Y, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_Z, '0));
    dir_rows.push_back(cfg_row(REG_AXIS_X, 48'h0000_0000_7fff));
    dir_rows.push_back(want_row(CMD_FWD_DIR, CMAX, 5, 5, CMAX, 0, 0, 1'b1));
    dir_rows.push_back(want_row(CMD_FWD_DIR, CMIN, 5, 5, CMIN, 0, 0, 1'b1));
    // Extreme coefficients and translations; the inverse point difference needs 33 bits.
    dir_rows.push_back(cfg_row(REG_AXIS_X, 48'h7fff_7fff_7fff));
    dir_rows.push_back(cfg_row(REG_AXIS_Y, 48'h8000_8000_8000));
    dir_rows.push_back(cfg_row(REG_AXIS_Z, 48'hffff_ffff_ffff));
    dir_rows.push_back(cfg_row(REG_OFFSET_X, {16'h0000, CMAX}));
    dir_rows.push_back(cfg_row(REG_OFFSET_Y, {16'h0000, CMIN}));
    dir_rows.push_back(cfg_row(REG_OFFSET_Z, {16'h0000, CMAX}));
    dir_rows.push_back(pt_row(CMD_FWD_POINT, CMAX, CMAX, CMAX));
    dir_rows.push_back(pt_row(CMD_FWD_POINT, CMIN, CMIN, CMIN));
    dir_rows.push_back(pt_row(CMD_INV_POINT, CMIN, CMAX, CMIN));
    dir_rows.push_back(pt_row(CMD_INV_DIR, CMAX, CMIN, CMAX));
    dir_rows.push_back(pt_row(CMD_FWD_DIR, 0, 0, 0));
    // Gain of one LSB on x and y puts exact halves on the rounding step.
    dir_rows.push_back(cfg_row(REG_AXIS_X, 48'h0000_0000_0001));
    dir_rows.push_back(cfg_row(REG_AXIS_Y, 48'h0000_0001_0000));
    dir_rows.push_back(cfg_row(REG_AXIS_Z, {COEF_ONE, 32'h0000_0000}));
    dir_rows.push_back(cfg_row(REG_OFFSET_X, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_Y, '0));
    dir_rows.push_back(cfg_row(REG_OFFSET_Z, '0));
    dir_rows.push_back(pt_row(CMD_FWD_DIR, 2048, -2048, 5));
    dir_rows.push_back(pt_row(CMD_FWD_DIR, -2049, 2047, -5));
    dir_rows.push_back(pt_row(CMD_INV_DIR, 6143, -6144, 0));
    dir_rows.push_back(pt_row(CMD_INV_POINT, -2048, 2049, 1));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        settle();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        push_point(dir_rows[r]);
      end
    end

    // Random phases: cycle through the configuration styles, each with fresh
    // random translations (and random axes for all but the identity style), then stream random points.
    for (int p = 0; p < PHASES; p++) begin
      style = cfg_style_e'(p % 4);
      settle();
      for (int a = 0; a < NumAxes; a++) begin
        word = '0;
        for (int c = 0; c < NumAxes; c++) begin
          case (style)
            STYLE_IDENTITY:  cf = (a == c) ? COEF_ONE : '0;
            STYLE_RANDOM:    cf = 16'($urandom);
            STYLE_NEAR_UNIT: cf = ((a == c) ? COEF_ONE : 16'h0000)
                                  + 16'($urandom_range(0, 1023)) - 16'd512;
            default:         cf = COEF_EDGES[$urandom_range(0, 3)];
          endcase
          word[CoefW*c +: CoefW] = cf;
        end
        write_reg(CfgIdxW'(REG_AXIS_X + a), word);
      end
      for (int a = 0; a < NumAxes; a++) begin
        case (style)
          STYLE_NEAR_UNIT: off = coord_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
          STYLE_EXTREME:   off = $urandom_range(0, 1) ? CMAX : CMIN;
          default:         off = coord_t'($urandom);
        endcase
        write_reg(CfgIdxW'(REG_OFFSET_X + a), {16'($urandom), off});
      end
      write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, {16'($urandom), $urandom});

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        row = pt_row(apt_cmd_e'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord());
        push_point(row);
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    in_ch.valid <= 1'b0;
    while (want_points.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/apt_pkg.sv
design/apt_if.sv
design/apt_lane.sv
design/apt_merge.sv
design/affine_point_transform_top.sv
tb/tb_affine_point_transform_top.sv
